// ===== src/mid_pkg.sv =====
// Shared types, codes and helpers for the mobile identity element decoder.
// Used by the controller, the datapath and the top level; depends on nothing.
package mid_pkg;

    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 4;
    localparam int KIND_W   = 2;
    localparam int RTYPE_W  = 2;
    localparam int INDEX_W  = 4;
    localparam int TDATA_W  = 16;
    localparam int TUSER_W  = 4;

    localparam logic [COUNT_W-1:0] GUTI_LEN       = 4'd10;
    localparam logic [COUNT_W-1:0] GUTI_MIN_BYTES = 4'd11;
    localparam logic [3:0]         DIGIT_MAX      = 4'd9;

    localparam logic [KIND_W-1:0] KIND_IMSI  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_IMEI  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GUTI  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;

    localparam logic [RTYPE_W-1:0] RT_DIGIT = 2'd0;
    localparam logic [RTYPE_W-1:0] RT_OCTET = 2'd1;
    localparam logic [RTYPE_W-1:0] RT_END   = 2'd2;

    localparam logic [2:0] TYPE_IMSI    = 3'd1;
    localparam logic [2:0] TYPE_IMEI    = 3'd2;
    localparam logic [2:0] TYPE_IMEISV  = 3'd3;
    localparam logic [2:0] TYPE_GUTI    = 3'd6;

    typedef enum logic [1:0] {
        SEL_DIGIT_LO,
        SEL_DIGIT_HI,
        SEL_OCTET,
        SEL_END
    } out_sel_t;

    typedef struct packed {
        logic     accept;
        logic     load;
        out_sel_t sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic first;
        logic digits;
        logic guti;
        logic guti_full;
        logic last;
        logic lo_ok;
        logic hi_ok;
        logic oct_done;
        logic out_free;
    } dp_status_t;

    function automatic logic [KIND_W-1:0] kind_of(input logic [BYTE_W-1:0] first_byte);
        logic [KIND_W-1:0] k;
        unique case (first_byte[2:0])
            TYPE_IMSI:               k = KIND_IMSI;
            TYPE_IMEI, TYPE_IMEISV:  k = KIND_IMEI;
            TYPE_GUTI:               k = KIND_GUTI;
            default:                 k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

// ===== src/mobile_identity_ie_decoder_top.sv =====
// Top level of the mobile identity element decoder.
// Instantiates mid_controller and mid_datapath; depends on mid_pkg.
//
// Bytes of one identity element arrive as input words, s_tlast on the final
// byte. IMSI and IMEI elements yield BCD digit words, GUTI elements yield
// ten octet words at the end when at least eleven bytes arrived, and every
// element closes with an end word carrying kind and status on m_tlast. An
// input word passes the controller states for accept, low digit and high
// digit, the controller giving each digit that a byte may yield a state of
// its own; the final byte adds the end word state and, for a full GUTI, the
// octet state, and any stall on m_tready holds the controller in the state
// that waits to load the output.
module mobile_identity_ie_decoder_top import mid_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,   // ie_byte[7:0]
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // value[7:0], octet_index[11:8], status[12], zeros
    output logic [TUSER_W-1:0]  m_tuser,   // result_type[1:0], kind[3:2]
    output logic                m_tlast
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    mid_controller u_controller (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mid_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== src/mid_datapath.sv =====
// Datapath of the mobile identity element decoder: byte and kind registers,
// the GUTI octet store and the output register. Depends on mid_pkg.
module mid_datapath import mid_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    input  logic [BYTE_W-1:0]    in_byte,
    input  logic                 in_last,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // value[7:0], octet_index[11:8], status[12], zeros
    output logic [TUSER_W-1:0]   m_tuser,   // result_type[1:0], kind[3:2]
    output logic                 m_tlast
);

    logic [BYTE_W-1:0]  byte_reg;
    logic               last_reg;
    logic               first_reg;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [INDEX_W-1:0] oct_idx_reg;
    logic [BYTE_W-1:0]  guti_reg [GUTI_LEN];
    logic [INDEX_W-1:0] wr_idx;
    logic               guti_wr;

    logic               m_valid_reg, m_valid_next;
    logic [RTYPE_W-1:0] rtype_reg, rtype_next;
    logic [BYTE_W-1:0]  value_reg, value_next;
    logic [INDEX_W-1:0] index_reg, index_next;
    logic [KIND_W-1:0]  okind_reg, okind_next;
    logic               ostatus_reg, ostatus_next;
    logic               olast_reg, olast_next;

    always_comb begin
        kind_next = (byte_count_reg == '0) ? kind_of(in_byte) : kind_reg;
        wr_idx    = byte_count_reg - 4'd1;
        guti_wr   = cmd.accept && (kind_next == KIND_GUTI) && (byte_count_reg != '0)
                    && (byte_count_reg <= GUTI_LEN);
        byte_count_next = byte_count_reg;
        if (cmd.accept && (byte_count_reg < GUTI_MIN_BYTES)) begin
            byte_count_next = byte_count_reg + 4'd1;
        end else if (cmd.load && (cmd.sel == SEL_END)) begin
            byte_count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            kind_reg       <= KIND_IMSI;
        end else begin
            byte_count_reg <= byte_count_next;
            if (cmd.accept) begin
                kind_reg <= kind_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            byte_reg  <= in_byte;
            last_reg  <= in_last;
            first_reg <= (byte_count_reg == '0);
        end
        if (guti_wr) begin
            guti_reg[wr_idx] <= in_byte;
        end
        if (cmd.accept) begin
            oct_idx_reg <= '0;
        end else if (cmd.load && (cmd.sel == SEL_OCTET)) begin
            oct_idx_reg <= oct_idx_reg + 4'd1;
        end
    end

    always_comb begin
        status.first     = first_reg;
        status.digits    = (kind_reg == KIND_IMSI) || (kind_reg == KIND_IMEI);
        status.guti      = (kind_reg == KIND_GUTI);
        status.guti_full = (byte_count_reg >= GUTI_MIN_BYTES);
        status.last      = last_reg;
        status.lo_ok     = (byte_reg[3:0] <= DIGIT_MAX);
        status.hi_ok     = (byte_reg[7:4] <= DIGIT_MAX);
        status.oct_done  = (oct_idx_reg == GUTI_LEN - 4'd1);
        status.out_free  = !m_valid_reg || m_tready;
    end

    always_comb begin
        rtype_next   = rtype_reg;
        value_next   = value_reg;
        index_next   = index_reg;
        okind_next   = okind_reg;
        ostatus_next = ostatus_reg;
        olast_next   = olast_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (cmd.load) begin
            m_valid_next = 1'b1;
            okind_next   = kind_reg;
            index_next   = '0;
            ostatus_next = 1'b0;
            olast_next   = 1'b0;
            unique case (cmd.sel)
                SEL_DIGIT_LO: begin
                    rtype_next = RT_DIGIT;
                    value_next = {4'd0, byte_reg[3:0]};
                end
                SEL_DIGIT_HI: begin
                    rtype_next = RT_DIGIT;
                    value_next = {4'd0, byte_reg[7:4]};
                end
                SEL_OCTET: begin
                    rtype_next = RT_OCTET;
                    value_next = guti_reg[oct_idx_reg];
                    index_next = oct_idx_reg;
                end
                SEL_END: begin
                    rtype_next   = RT_END;
                    value_next   = '0;
                    ostatus_next = (kind_reg == KIND_GUTI) && !status.guti_full;
                    olast_next   = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        rtype_reg   <= rtype_next;
        value_reg   <= value_next;
        index_reg   <= index_next;
        okind_reg   <= okind_next;
        ostatus_reg <= ostatus_next;
        olast_reg   <= olast_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, ostatus_reg, index_reg, value_reg};
    assign m_tuser  = {okind_reg, rtype_reg};
    assign m_tlast  = olast_reg;

endmodule

// ===== src/mid_controller.sv =====
// Controller of the mobile identity element decoder: sequences the results
// of each input word. Depends on mid_pkg.
module mid_controller import mid_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LO    = 3'd1;
    localparam logic [2:0] ST_HI    = 3'd2;
    localparam logic [2:0] ST_OCTET = 3'd3;
    localparam logic [2:0] ST_END   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] after_hi;

    always_comb begin
        after_hi = ST_IDLE;
        if (status.last) begin
            after_hi = (status.guti && status.guti_full) ? ST_OCTET : ST_END;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.load   = 1'b0;
        cmd.sel    = SEL_END;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_LO;
                end
            end
            ST_LO: begin
                cmd.sel = SEL_DIGIT_LO;
                if (status.digits && !status.first && status.lo_ok) begin
                    if (status.out_free) begin
                        cmd.load   = 1'b1;
                        state_next = ST_HI;
                    end
                end else begin
                    state_next = ST_HI;
                end
            end
            ST_HI: begin
                cmd.sel = SEL_DIGIT_HI;
                if (status.digits && status.hi_ok) begin
                    if (status.out_free) begin
                        cmd.load   = 1'b1;
                        state_next = after_hi;
                    end
                end else begin
                    state_next = after_hi;
                end
            end
            ST_OCTET: begin
                cmd.sel = SEL_OCTET;
                if (status.out_free) begin
                    cmd.load = 1'b1;
                    if (status.oct_done) begin
                        state_next = ST_END;
                    end
                end
            end
            ST_END: begin
                cmd.sel = SEL_END;
                if (status.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
